// ===== src/qdec_pkg.sv =====
package qdec_pkg;

  // Defaults for the top-level parameters
  localparam int MOTOR_COUNT_DEF = 2;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int POS_W   = 16;
  localparam int SCALE_W = 16;
  localparam int SPEED_W = 33;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2513;

  // Register indexes (paddr[2])
  typedef enum logic [0:0] {
    REG_SPEED_SCALE = 1'b0
  } reg_idx_t;

  // Item operations
  typedef enum logic [0:0] {
    OP_PIN  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

endpackage

// ===== src/qdec_ram.sv =====
module qdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/qdec_regs.sv =====
module qdec_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qdec_pkg::PADDR_W-1:0] paddr,
  input  logic [qdec_pkg::PDATA_W-1:0] pwdata,
  output logic [qdec_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [qdec_pkg::SCALE_W-1:0] speed_scale
);

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == qdec_pkg::REG_SPEED_SCALE);

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= qdec_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      speed_scale <= pwdata[qdec_pkg::SCALE_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = qdec_pkg::PDATA_W'(speed_scale);
    end
  end

endmodule

// ===== src/quadrature_decoder_with_speed.sv =====
// Quadrature decoder (x4) with sampled speed, one state entry per motor.
//
// Input channel (in_valid / in_stall): one request per item. operation
// selects a pin sample (phase_a/phase_b levels of one motor) or a speed
// sample tick for that motor. Each request gives exactly one result.
// Output channel (out_valid / out_stall): motor_out, position_count,
// direction, and on tick results speed_valid = 1 with a signed Q.8 speed.
// speed_scale (Q8.8) is written over the APB port at address 0.
//
// From input acceptance to out_valid an item passes the read stage (state
// memory read), then the output register (update and speed multiply).
// Throughput is one item per cycle while the receiver does not stall;
// back-to-back requests to the same motor forward the just-written entry
// around the memory. When the receiver stalls, the result holds in the
// output register, one more item waits in the read stage; in_stall rises.
// Reset clears all motor state (per-entry valid bits), speed_scale returns
// to 2513 and both pipeline stages empty; no clearing pass is needed.
module quadrature_decoder_with_speed #(
  parameter int MOTOR_COUNT = qdec_pkg::MOTOR_COUNT_DEF,
  parameter int COUNT_WIDTH = qdec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic                                motor,
  input  logic                                phase_a,
  input  logic                                phase_b,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                motor_out,
  output logic [qdec_pkg::POS_W-1:0]          position_count,
  output logic                                direction,
  output logic                                speed_valid,
  output logic signed [qdec_pkg::SPEED_W-1:0] speed,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qdec_pkg::PADDR_W-1:0]        paddr,
  input  logic [qdec_pkg::PDATA_W-1:0]        pwdata,
  output logic [qdec_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int AW     = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int PROD_W = COUNT_WIDTH + qdec_pkg::SCALE_W;
  localparam logic HAS_M1 = (MOTOR_COUNT > 1);

  typedef struct packed {
    logic                   last_a;
    logic                   last_b;
    logic                   dir;
    logic [COUNT_WIDTH-1:0] edge_cnt;
    logic [COUNT_WIDTH-1:0] tick_cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  logic [qdec_pkg::SCALE_W-1:0] speed_scale;

  // read stage
  logic               s1_valid;
  logic               s1_op;
  logic               s1_in_range;
  logic               s1_motor;
  logic               s1_a;
  logic               s1_b;
  logic               s1_adv;
  logic               in_acc;
  logic               in_range;
  logic [AW-1:0]      rd_addr;

  // state memory and forwarding
  logic [MOTOR_COUNT-1:0] ent_valid;
  logic                   ent_vld_q;
  logic                   byp_hit;
  logic [ENTRY_W-1:0]     byp_data;
  logic [ENTRY_W-1:0]     rdata;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  entry_t                 cur;
  entry_t                 nxt;
  logic [COUNT_WIDTH-1:0] cnt1;
  logic                   dir1;
  logic [COUNT_WIDTH-1:0] diff;
  logic [PROD_W-1:0]      prod;

  // output register
  logic                          out_neg;
  logic [qdec_pkg::SPEED_W-1:0]  out_mag;

  qdec_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .speed_scale (speed_scale)
  );

  // Handshake: read stage moves on when the output register is free or draining
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign in_range = HAS_M1 || !motor;
  assign rd_addr  = AW'(motor);

  qdec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MOTOR_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (nxt),
    .re    (in_acc && in_range),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Read stage registers, valid-bit sample and same-entry forward
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      ent_valid <= '0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
    end
    if (in_acc) begin
      s1_op       <= operation;
      s1_motor    <= motor;
      s1_a        <= phase_a;
      s1_b        <= phase_b;
      s1_in_range <= in_range;
      ent_vld_q   <= in_range && ent_valid[rd_addr];
      byp_hit     <= in_range && wr_en && (wr_addr == rd_addr);
      byp_data    <= nxt;
    end
  end

  assign wr_en   = s1_adv && s1_in_range;
  assign wr_addr = AW'(s1_motor);

  // Entry update: A change then B change, or a tick capture
  always_comb begin
    cur = '0;
    if (byp_hit) begin
      cur = entry_t'(byp_data);
    end else if (ent_vld_q) begin
      cur = entry_t'(rdata);
    end
    nxt  = cur;
    cnt1 = cur.edge_cnt;
    dir1 = cur.dir;
    diff = '0;
    if (s1_op == qdec_pkg::OP_PIN) begin
      if (s1_a != cur.last_a) begin
        dir1 = (s1_a != s1_b);
        cnt1 = dir1 ? cur.edge_cnt + 1'b1 : cur.edge_cnt - 1'b1;
      end
      nxt.last_a   = s1_a;
      nxt.last_b   = s1_b;
      nxt.dir      = dir1;
      nxt.edge_cnt = cnt1;
      if (s1_b != cur.last_b) begin
        nxt.dir      = (s1_a == s1_b);
        nxt.edge_cnt = nxt.dir ? cnt1 + 1'b1 : cnt1 - 1'b1;
      end
    end else begin
      diff = cur.dir ? cur.edge_cnt - cur.tick_cnt : cur.tick_cnt - cur.edge_cnt;
      nxt.tick_cnt = cur.edge_cnt;
    end
  end

  assign prod = PROD_W'(diff) * PROD_W'(speed_scale);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_adv) begin
      motor_out      <= s1_motor;
      position_count <= '0;
      direction      <= 1'b0;
      speed_valid    <= 1'b0;
      out_mag        <= '0;
      out_neg        <= 1'b0;
      if (s1_in_range) begin
        position_count <= qdec_pkg::POS_W'(nxt.edge_cnt);
        direction      <= nxt.dir;
        if (s1_op == qdec_pkg::OP_TICK) begin
          speed_valid <= 1'b1;
          out_mag     <= qdec_pkg::SPEED_W'(prod);
          out_neg     <= cur.dir;
        end
      end
    end
  end

  // Up direction gives a negative speed
  assign speed = out_neg ? $signed(~out_mag + 1'b1) : $signed(out_mag);

endmodule

// ===== src/qdec_checker.sv =====
module qdec_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [qdec_pkg::POS_W-1:0]          position_count,
  input logic                                speed_valid,
  input logic signed [qdec_pkg::SPEED_W-1:0] speed
);

  // Pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // An empty output register never backs up the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("in_stall with empty output register");

  // Pin-sample results carry no speed
  a_pin_speed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !speed_valid |-> speed == '0)
    else $error("nonzero speed on pin-sample result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position_count) && $stable(speed))
    else $error("stalled result changed");

endmodule

bind quadrature_decoder_with_speed qdec_checker u_qdec_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .position_count (position_count),
  .speed_valid    (speed_valid),
  .speed          (speed)
);
